/* rtl/core/dcsd_pkg.sv */
// Shared types and constants for the command stream decoder.
package dcsd_pkg;

  localparam int MAP_DEPTH = 128;
  localparam int MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int CFG_AW = 5;

  // input command kinds
  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_MAP     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  // old-format opcodes and repair constants
  localparam logic [7:0] OP_DELAY8   = 8'h00;
  localparam logic [7:0] OP_REG1     = 8'h01;
  localparam logic [7:0] OP_PORT0    = 8'h02;
  localparam logic [7:0] OP_PORT1    = 8'h03;
  localparam logic [7:0] OP_ESC      = 8'h04;
  localparam logic [7:0] ESC_LIMIT   = 8'h08;
  localparam logic [7:0] R1_TAIL_LOW = 8'h08;
  localparam logic [7:0] R1_TAIL_MIN = 8'h20;
  localparam logic [7:0] R1_ALT_B0   = 8'h20;
  localparam logic [7:0] REG_R1      = 8'h01;
  localparam logic [7:0] REG_ESC     = 8'h04;
  localparam int         PORT_BIT    = 7;

  localparam logic EV_WRITE = 1'b0;
  localparam logic EV_END   = 1'b1;

  typedef enum logic [2:0] {
    REG_FORMAT_MODE = 3'd0,
    REG_SHORT_CODE  = 3'd1,
    REG_LONG_CODE   = 3'd2,
    REG_MAP_COUNT   = 3'd3,
    REG_INIT_END    = 3'd4,
    REG_PORT_COUNT  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic        format_mode;
    logic [7:0]  short_delay_code;
    logic [7:0]  long_delay_code;
    logic [7:0]  map_count;
    logic [31:0] init_end_offset;
    logic [1:0]  port_count;
  } cfg_t;

  typedef struct packed {
    logic        event_kind;
    logic        port;
    logic [7:0]  register_number;
    logic [7:0]  write_data;
    logic [31:0] due_tick;
    logic        last_of_run;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

endpackage

/* rtl/core/dcsd_cfg_regs.sv */
// Configuration register file with the register bus write and read decode.
module dcsd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dcsd_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output dcsd_pkg::cfg_t             cfg,
  output logic                       fmt_wr
);
  import dcsd_pkg::*;

  cfg_t     cfg_r;
  cfg_idx_t idx;
  logic     wr;

  assign idx    = cfg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel & penable & pwrite;
  assign fmt_wr = wr && (idx == REG_FORMAT_MODE);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.format_mode      <= 1'b1;
      cfg_r.short_delay_code <= 8'h00;
      cfg_r.long_delay_code  <= 8'h01;
      cfg_r.map_count        <= 8'h00;
      cfg_r.init_end_offset  <= 32'h0;
      cfg_r.port_count       <= 2'd1;
    end else if (wr) begin
      unique case (idx)
        REG_FORMAT_MODE: cfg_r.format_mode      <= pwdata[0];
        REG_SHORT_CODE:  cfg_r.short_delay_code <= pwdata[7:0];
        REG_LONG_CODE:   cfg_r.long_delay_code  <= pwdata[7:0];
        REG_MAP_COUNT:   cfg_r.map_count        <= pwdata[7:0];
        REG_INIT_END:    cfg_r.init_end_offset  <= pwdata;
        REG_PORT_COUNT:  cfg_r.port_count       <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FORMAT_MODE: prdata = {31'd0, cfg_r.format_mode};
      REG_SHORT_CODE:  prdata = {24'd0, cfg_r.short_delay_code};
      REG_LONG_CODE:   prdata = {24'd0, cfg_r.long_delay_code};
      REG_MAP_COUNT:   prdata = {24'd0, cfg_r.map_count};
      REG_INIT_END:    prdata = cfg_r.init_end_offset;
      REG_PORT_COUNT:  prdata = {30'd0, cfg_r.port_count};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/core/dcsd_parser.sv */
// Stream byte parser: phase machine, tick accumulator and register map memory.
module dcsd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  dcsd_pkg::cfg_t      cfg,
  input  logic                fmt_wr,
  input  logic                acc,
  input  logic [1:0]          command,
  input  logic [7:0]          stream_byte,
  input  logic [6:0]          map_index,
  input  logic [7:0]          map_value,
  input  logic                final_byte,
  output dcsd_pkg::push_t     push
);
  import dcsd_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_DELAY8 = 3'd1,
    PH_R1_B0  = 3'd2,
    PH_R1_B1  = 3'd3,
    PH_ESC    = 3'd4,
    PH_DATA   = 3'd6,
    PH_PAIR   = 3'd7
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic        sel_port_r, sel_port_nxt;
  logic [7:0]  held_cmd_r, held_cmd_nxt;
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] tick_r, tick_nxt;
  logic        ended_r, ended_nxt;

  logic [7:0]  map_mem [MAP_DEPTH];
  logic [7:0]  map_q_r;

  logic        load_acc, restart_acc, byte_acc;
  logic        rd_en, fwd_hit;
  logic        pos_before_init;
  logic        idx_valid;
  logic [16:0] delta;
  logic [31:0] tick_sum;
  logic        w_emit, w_ok, e_emit;
  logic        w_port;
  logic [7:0]  w_reg;
  logic [7:0]  w_data;
  res_t        wres, eres;

  assign load_acc    = acc && (command == CMD_MAP);
  assign restart_acc = acc && (command == CMD_RESTART);
  assign byte_acc    = acc && (command == CMD_BYTE) && !ended_r;

  assign pos_before_init = pos_r < cfg.init_end_offset;
  assign idx_valid = ({1'b0, held_cmd_r[6:0]} < cfg.map_count) &&
                     ({1'b0, held_cmd_r[6:0]} < 8'(MAP_DEPTH));
  assign tick_sum  = tick_r + 32'(delta);

  // map entry read is launched with the first byte of a pair; a load that
  // lands on the held entry before the second byte is forwarded
  assign fwd_hit = load_acc && (8'(map_index) < 8'(MAP_DEPTH)) &&
                   (map_index[MAP_AW-1:0] == held_cmd_r[MAP_AW-1:0]);

  always_ff @(posedge clk) begin
    if (load_acc && (8'(map_index) < 8'(MAP_DEPTH))) begin
      map_mem[map_index[MAP_AW-1:0]] <= map_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      map_q_r <= map_mem[stream_byte[MAP_AW-1:0]];
    end else if (fwd_hit) begin
      map_q_r <= map_value;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    sel_port_nxt  = sel_port_r;
    held_cmd_nxt  = held_cmd_r;
    held_byte_nxt = held_byte_r;
    pos_nxt       = pos_r;
    tick_nxt      = tick_r;
    ended_nxt     = ended_r;
    rd_en         = 1'b0;
    delta         = 17'd0;
    w_emit        = 1'b0;
    w_port        = sel_port_r;
    w_reg         = held_cmd_r;
    w_data        = stream_byte;
    e_emit        = 1'b0;

    if (restart_acc) begin
      phase_nxt     = PH_IDLE;
      sel_port_nxt  = 1'b0;
      held_cmd_nxt  = 8'h00;
      held_byte_nxt = 8'h00;
      pos_nxt       = 32'd0;
      tick_nxt      = 32'd0;
      ended_nxt     = 1'b0;
    end else if (fmt_wr) begin
      phase_nxt = PH_IDLE;
    end else if (byte_acc) begin
      if (pos_r != 32'hFFFF_FFFF) begin
        pos_nxt = pos_r + 32'd1;
      end
      if (cfg.format_mode) begin
        if (phase_r != PH_PAIR) begin
          held_cmd_nxt = stream_byte;
          phase_nxt    = PH_PAIR;
          rd_en        = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
          if (held_cmd_r == cfg.short_delay_code) begin
            delta = 17'(stream_byte) + 17'd1;
          end else if (held_cmd_r == cfg.long_delay_code) begin
            delta = {(9'(stream_byte) + 9'd1), 8'h00};
          end else if (idx_valid) begin
            w_emit = 1'b1;
            w_port = held_cmd_r[PORT_BIT];
            w_reg  = map_q_r;
          end
        end
      end else begin
        unique case (phase_r)
          PH_IDLE: begin
            case (stream_byte) inside
              OP_DELAY8:          phase_nxt = PH_DELAY8;
              OP_REG1:            phase_nxt = PH_R1_B0;
              OP_PORT0, OP_PORT1: sel_port_nxt = stream_byte[0];
              OP_ESC:             phase_nxt = PH_ESC;
              default: begin
                held_cmd_nxt = stream_byte;
                phase_nxt    = PH_DATA;
              end
            endcase
          end
          PH_DELAY8: begin
            delta     = 17'(stream_byte) + 17'd1;
            phase_nxt = PH_IDLE;
          end
          PH_R1_B0: begin
            if (pos_before_init) begin
              w_emit    = 1'b1;
              w_reg     = REG_R1;
              phase_nxt = PH_IDLE;
            end else begin
              held_byte_nxt = stream_byte;
              phase_nxt     = PH_R1_B1;
            end
          end
          PH_R1_B1: begin
            // on a match held byte is reg 1 data; this byte opens a new write
            if ((held_byte_r == 8'h00 || held_byte_r == R1_ALT_B0) &&
                (stream_byte == R1_TAIL_LOW || stream_byte >= R1_TAIL_MIN)) begin
              w_emit       = 1'b1;
              w_reg        = REG_R1;
              w_data       = held_byte_r;
              held_cmd_nxt = stream_byte;
              phase_nxt    = PH_DATA;
            end else begin
              delta     = 17'({stream_byte, held_byte_r}) + 17'd1;
              phase_nxt = PH_IDLE;
            end
          end
          PH_ESC: begin
            if (stream_byte >= ESC_LIMIT || pos_before_init) begin
              w_emit    = 1'b1;
              w_reg     = REG_ESC;
              phase_nxt = PH_IDLE;
            end else begin
              held_cmd_nxt = stream_byte;
              phase_nxt    = PH_DATA;
            end
          end
          PH_DATA: begin
            w_emit    = 1'b1;
            phase_nxt = PH_IDLE;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      tick_nxt = tick_sum;
      if (final_byte) begin
        e_emit    = 1'b1;
        ended_nxt = 1'b1;
        phase_nxt = PH_IDLE;
      end
    end
  end

  // write to an absent port is dropped
  assign w_ok = w_emit && ({1'b0, w_port} < cfg.port_count);

  always_comb begin
    wres.event_kind      = EV_WRITE;
    wres.port            = w_port;
    wres.register_number = w_reg;
    wres.write_data      = w_data;
    wres.due_tick        = tick_r;
    wres.last_of_run     = !e_emit;
    eres.event_kind      = EV_END;
    eres.port            = 1'b0;
    eres.register_number = 8'h00;
    eres.write_data      = 8'h00;
    eres.due_tick        = tick_sum;
    eres.last_of_run     = 1'b1;
    push.v0 = w_ok | e_emit;
    push.v1 = w_ok & e_emit;
    push.r0 = w_ok ? wres : eres;
    push.r1 = eres;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sel_port_r  <= 1'b0;
      held_cmd_r  <= 8'h00;
      held_byte_r <= 8'h00;
      pos_r       <= 32'd0;
      tick_r      <= 32'd0;
      ended_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      sel_port_r  <= sel_port_nxt;
      held_cmd_r  <= held_cmd_nxt;
      held_byte_r <= held_byte_nxt;
      pos_r       <= pos_nxt;
      tick_r      <= tick_nxt;
      ended_r     <= ended_nxt;
    end
  end

  a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
    byte_acc && final_byte |=> ended_r)
    else $error("final byte did not end the stream");

  a_ended_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> phase_r == PH_IDLE)
    else $error("partial command held after end of stream");

  a_ended_silent: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> !push.v0 && !push.v1)
    else $error("result produced after end of stream");

endmodule

/* rtl/core/dcsd_out_fifo.sv */
// Result buffer: takes up to two results a cycle, hands out one per transfer.
module dcsd_out_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  dcsd_pkg::push_t push,
  output logic            room,
  output logic            out_valid,
  input  logic            out_ready,
  output dcsd_pkg::res_t  out_res
);
  import dcsd_pkg::*;

  res_t                 buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic                 pop;
  logic [FIFO_AW-1:0]   wr_ptr_p1;

  assign pop       = out_valid & out_ready;
  assign out_valid = (count_r != '0);
  assign out_res   = buf_q[rd_ptr_r];
  assign room      = (count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.v0) + FIFO_AW'(push.v1);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW+1)'(push.v0) + (FIFO_AW+1)'(push.v1)
                 - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      buf_q[wr_ptr_r] <= push.r0;
    end
    if (push.v1) begin
      buf_q[wr_ptr_p1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result buffer overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> count_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2))
    else $error("results pushed without room");

  a_pair_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> push.v0 && !push.r0.last_of_run && push.r1.last_of_run)
    else $error("two-result run malformed");

endmodule

/* rtl/core/dro_command_stream_decoder.sv */
// Top level of the register-capture command stream decoder.
//
// Decodes a captured sound-chip register log, one byte per input transfer,
// into timed register writes, each stamped with the wrapping tick count at
// which it takes effect; the byte flagged by tlast also yields an end event.
// Rate: one input transfer per clock, sustained, while the result side keeps
// up. Each input causes zero, one or two results; results go through a
// four-entry buffer, and in_tready is high whenever that buffer has room for
// two more, so a stalled or slow result side is what throttles input. In the
// paired format the register map (a synchronous memory) is read
// when the first byte of a pair arrives, so the second byte may follow in the
// very next cycle; a map load to the same entry in between is forwarded. Map
// entries never loaded read back undefined. There is no clearing pass.
module dro_command_stream_decoder (
  input  logic                        clk,
  input  logic                        rst_n,
  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [23:0]                 in_tdata,  // stream_byte, map_index, map_value, pad
  input  logic [1:0]                  in_tuser,  // command
  input  logic                        in_tlast,  // final_byte
  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [55:0]                 out_tdata, // port, register_number, write_data, due_tick, pad
  output logic                        out_tuser, // event_kind
  output logic                        out_tlast, // last_of_run
  // configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [dcsd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);
  import dcsd_pkg::*;

  cfg_t  cfg;
  logic  fmt_wr;
  logic  acc;
  logic  room;
  push_t push;
  res_t  head;

  assign cfg_pready = 1'b1;
  assign in_tready  = room;
  assign acc        = in_tvalid & in_tready;

  dcsd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg),
    .fmt_wr  (fmt_wr)
  );

  // field unpack: stream byte low, then map index, then map value
  dcsd_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .fmt_wr      (fmt_wr),
    .acc         (acc),
    .command     (in_tuser),
    .stream_byte (in_tdata[7:0]),
    .map_index   (in_tdata[14:8]),
    .map_value   (in_tdata[22:15]),
    .final_byte  (in_tlast),
    .push        (push)
  );

  dcsd_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (head)
  );

  // result pack; in_tdata[23] is padding and unused by design
  assign out_tdata = {7'd0, head.due_tick, head.write_data,
                      head.register_number, head.port};
  assign out_tuser = head.event_kind;
  assign out_tlast = head.last_of_run;

endmodule

/* dv/tb_dro_command_stream_decoder.sv */
// Self-checking testbench for the register-capture command stream decoder.
`timescale 1ns / 100ps

module tb_dro_command_stream_decoder;
  import dcsd_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;
  localparam int         STALL_LIMIT  = 2000;  // cycles with no transfer anywhere
  localparam int         SETTLE       = 8;     // cycles after drain before a reg write
  localparam int         PHASES       = 12;
  localparam int         PHASE_ITEMS  = 18;

  // parse states of the decoder, as tracked by the predictor
  typedef enum logic [2:0] {
    P_IDLE   = 3'd0,
    P_DELAY8 = 3'd1,
    P_R1_B0  = 3'd2,
    P_R1_B1  = 3'd3,
    P_ESC    = 3'd4,
    P_DATA   = 3'd6,
    P_PAIR   = 3'd7
  } parse_t;

  // one input transfer
  typedef struct {
    logic [1:0] cmd;
    logic [7:0] sbyte;
    logic [6:0] midx;
    logic [7:0] mval;
    logic       fin;
  } xfer_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;  // stream_byte, map_index, map_value, pad
  logic [1:0]  in_tuser = '0;  // command
  logic        in_tlast = 1'b0;  // final_byte
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;  // port, register_number, write_data, due_tick, pad
  logic        out_tuser;  // event_kind
  logic        out_tlast;  // last_of_run
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  dro_command_stream_decoder DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the settings and of the parser state.
  // Settings start at their reset values.
  // ---------------------------------------------------------------------------
  logic        set_format     = 1'b1;
  logic [7:0]  set_short      = 8'h00;
  logic [7:0]  set_long       = 8'h01;
  logic [7:0]  set_map_count  = 8'h00;
  logic [31:0] set_init_end   = 32'h0;
  logic [1:0]  set_port_count = 2'd1;

  parse_t      dec_phase    = P_IDLE;
  logic        dec_port     = 1'b0;
  logic [7:0]  dec_cmd_hold = 8'h00;
  logic [7:0]  dec_byte_hold = 8'h00;
  logic [31:0] dec_pos      = 32'h0;
  logic [31:0] dec_ticks    = 32'h0;
  logic        dec_ended    = 1'b0;
  logic [7:0]  map_shadow [MAP_DEPTH];

  res_t  step_events[$];      // results of the transfer being decoded
  res_t  expected_events[$];  // results still owed by the block
  xfer_t send_queue[$];       // transfers not yet offered

  int n_transfers = 0;
  int n_writes    = 0;
  int n_ends      = 0;
  int n_errors    = 0;

  // a write reaches the output only if its port is present
  task automatic add_write(input logic port, input logic [7:0] regn, input logic [7:0] data);
    res_t r;
    if (port < set_port_count) begin
      r = '{event_kind: EV_WRITE, port: port, register_number: regn,
            write_data: data, due_tick: dec_ticks, last_of_run: 1'b0};
      step_events.insert(step_events.size(), r);
    end
  endtask

  // old single-byte command format, with the two repairs
  task automatic decode_old(input logic [7:0] b, input logic [31:0] pos);
    case (dec_phase)
      P_IDLE: begin
        if (b == OP_DELAY8) dec_phase = P_DELAY8;
        else if (b == OP_REG1) dec_phase = P_R1_B0;
        else if (b == OP_PORT0 || b == OP_PORT1) dec_port = b[0];
        else if (b == OP_ESC) dec_phase = P_ESC;
        else begin
          dec_cmd_hold = b;
          dec_phase = P_DATA;
        end
      end
      P_DELAY8: begin
        dec_ticks = dec_ticks + 32'd1 + b;
        dec_phase = P_IDLE;
      end
      P_R1_B0: begin
        // inside the init dump the byte is always register 1 data
        if (pos < set_init_end) begin
          add_write(dec_port, REG_R1, b);
          dec_phase = P_IDLE;
        end else begin
          dec_byte_hold = b;
          dec_phase = P_R1_B1;
        end
      end
      P_R1_B1: begin
        // unescaped register 1 write vs a 16-bit delay
        if ((dec_byte_hold & ~R1_ALT_B0) == 8'h00 && (b == R1_TAIL_LOW || b >= R1_TAIL_MIN)) begin
          add_write(dec_port, REG_R1, dec_byte_hold);
          dec_cmd_hold = b;
          dec_phase = P_DATA;
        end else begin
          dec_ticks = dec_ticks + 32'd1 + {16'h0, b, dec_byte_hold};
          dec_phase = P_IDLE;
        end
      end
      P_ESC: begin
        if (b >= ESC_LIMIT || pos < set_init_end) begin
          add_write(dec_port, REG_ESC, b);
          dec_phase = P_IDLE;
        end else begin
          dec_cmd_hold = b;
          dec_phase = P_DATA;
        end
      end
      P_DATA: begin
        add_write(dec_port, dec_cmd_hold, b);
        dec_phase = P_IDLE;
      end
      default: dec_phase = P_IDLE;
    endcase
  endtask

  // paired format: code byte then data byte
  task automatic decode_pair(input logic [7:0] b);
    logic [6:0] idx;
    if (dec_phase != P_PAIR) begin
      dec_cmd_hold = b;
      dec_phase = P_PAIR;
    end else begin
      dec_phase = P_IDLE;
      idx = dec_cmd_hold[6:0];
      if (dec_cmd_hold == set_short) dec_ticks = dec_ticks + 32'd1 + b;
      else if (dec_cmd_hold == set_long) dec_ticks = dec_ticks + ((32'd1 + b) << 8);
      else if (idx < set_map_count)
        add_write(dec_cmd_hold[PORT_BIT], map_shadow[idx], b);
    end
  endtask

  // expected results of one accepted transfer, appended to expected_events
  task automatic decode_transfer(input xfer_t x);
    logic [31:0] pos;
    res_t        r;
    step_events.delete();
    if (x.cmd == CMD_MAP) begin
      map_shadow[x.midx] = x.mval;
    end else if (x.cmd == CMD_RESTART) begin
      dec_phase = P_IDLE;
      dec_port = 1'b0;
      dec_cmd_hold = 8'h00;
      dec_byte_hold = 8'h00;
      dec_pos = 32'h0;
      dec_ticks = 32'h0;
      dec_ended = 1'b0;
    end else if (x.cmd == CMD_BYTE && !dec_ended) begin
      pos = dec_pos;
      if (dec_pos != 32'hFFFF_FFFF) dec_pos = dec_pos + 32'd1;
      if (set_format) decode_pair(x.sbyte);
      else decode_old(x.sbyte, pos);
      if (x.fin) begin
        // end event; any half-received command is thrown away
        r = '{event_kind: EV_END, port: 1'b0, register_number: 8'h00,
              write_data: 8'h00, due_tick: dec_ticks, last_of_run: 1'b0};
        step_events.insert(step_events.size(), r);
        dec_ended = 1'b1;
        dec_phase = P_IDLE;
      end
    end
    if (step_events.size() > 0) begin
      r = step_events.pop_back();
      r.last_of_run = 1'b1;
      step_events.insert(step_events.size(), r);
    end
    while (step_events.size() > 0)
      expected_events.insert(expected_events.size(), step_events.pop_front());
  endtask

  // ---------------------------------------------------------------------------
  // Idle patterns: mostly short gaps, some long, plus stretches with none.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    else if (r < 92) return $urandom_range(1, 3);
    else return $urandom_range(6, 30);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued transfers, predicts each one as it is accepted.
  // ---------------------------------------------------------------------------
  xfer_t cur_xfer;
  int    send_gap  = 0;
  int    send_calm = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_transfer(cur_xfer);
        n_transfers++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered transfer
      end else if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (send_queue.size() > 0) begin
        cur_xfer = send_queue.pop_front();
        in_tdata <= {1'b0, cur_xfer.mval, cur_xfer.midx, cur_xfer.sbyte};
        in_tuser <= cur_xfer.cmd;
        in_tlast <= cur_xfer.fin;
        in_tvalid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, each result transfer checked in order.
  // ---------------------------------------------------------------------------
  int   recv_stall = 0;
  int   recv_calm  = 0;
  res_t seen;
  res_t owed;

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp, act);
      n_errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = '{event_kind: out_tuser, port: out_tdata[0], register_number: out_tdata[8:1],
                 write_data: out_tdata[16:9], due_tick: out_tdata[48:17],
                 last_of_run: out_tlast};
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected result, expected none actual kind %0d reg 0x%0h data 0x%0h",
                   $time, seen.event_kind, seen.register_number, seen.write_data);
          n_errors++;
        end else begin
          owed = expected_events.pop_front();
          check_field("event_kind", owed.event_kind, seen.event_kind);
          check_field("port", owed.port, seen.port);
          check_field("register_number", owed.register_number, seen.register_number);
          check_field("write_data", owed.write_data, seen.write_data);
          check_field("due_tick", owed.due_tick, seen.due_tick);
          check_field("last_of_run", owed.last_of_run, seen.last_of_run);
          if (owed.event_kind == EV_END) n_ends++;
          else n_writes++;
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_stall = pick_gap();
          if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 60);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: ends the run if nothing moves on any port for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still owed",
                 $time, STALL_LIMIT, expected_events.size());
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_FORMAT_MODE: begin
        set_format = val[0];
        dec_phase = P_IDLE;  // a format change drops any partial command
      end
      REG_SHORT_CODE: set_short = val[7:0];
      REG_LONG_CODE:  set_long = val[7:0];
      REG_MAP_COUNT:  set_map_count = val[7:0];
      REG_INIT_END:   set_init_end = val;
      REG_PORT_COUNT: set_port_count = val[1:0];
      default: ;
    endcase
  endtask

  // sender holds off until every owed result has arrived
  task automatic wait_drained();
    while (send_queue.size() > 0 || in_tvalid || expected_events.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fin = 1'b0);
    xfer_t x;
    x = '{cmd: CMD_BYTE, sbyte: b, midx: 7'($urandom), mval: 8'($urandom), fin: fin};
    send_queue.insert(send_queue.size(), x);
  endtask

  task automatic push_load(input logic [6:0] idx, input logic [7:0] val);
    xfer_t x;
    x = '{cmd: CMD_MAP, sbyte: 8'($urandom), midx: idx, mval: val, fin: 1'($urandom)};
    send_queue.insert(send_queue.size(), x);
  endtask

  task automatic push_other(input logic [1:0] cmd);
    xfer_t x;
    x = '{cmd: cmd, sbyte: 8'($urandom), midx: 7'($urandom), mval: 8'($urandom),
          fin: 1'($urandom)};
    send_queue.insert(send_queue.size(), x);
  endtask

  // one old-format command with random content
  task automatic push_old_command();
    int         r;
    logic [7:0] b0;
    logic [7:0] b1;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      push_byte(OP_DELAY8);
      push_byte(8'($urandom));
    end else if (r < 32) begin
      // register 1 write or long delay, biased toward the repair pattern
      b0 = ($urandom_range(0, 9) < 4) ? ($urandom_range(0, 1) ? R1_ALT_B0 : 8'h00)
                                       : 8'($urandom);
      b1 = ($urandom_range(0, 1) == 0) ? 8'($urandom)
         : ($urandom_range(0, 2) == 0 ? R1_TAIL_LOW : 8'($urandom_range(32, 255)));
      push_byte(OP_REG1);
      push_byte(b0);
      push_byte(b1);
      if ((b0 & ~R1_ALT_B0) == 8'h00) push_byte(8'($urandom));
    end else if (r < 47) begin
      b0 = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      push_byte(OP_ESC);
      push_byte(b0);
      if (b0 < ESC_LIMIT) push_byte(8'($urandom));
    end else if (r < 57) begin
      push_byte($urandom_range(0, 1) ? OP_PORT1 : OP_PORT0);
    end else begin
      push_byte(8'($urandom_range(5, 255)));
      push_byte(8'($urandom));
    end
  endtask

  // one paired-format command with random content
  task automatic push_pair();
    int         r;
    logic [7:0] code;
    r = $urandom_range(0, 99);
    if (r < 20) code = set_short;
    else if (r < 40) code = set_long;
    else code = 8'($urandom);
    push_byte(code);
    // occasionally reload a map entry between the two bytes
    if (r >= 40 && $urandom_range(0, 9) == 0)
      push_load($urandom_range(0, 1) ? code[6:0] : 7'($urandom), 8'($urandom));
    push_byte(8'($urandom));
  endtask

  task automatic pick_settings(input int ph);
    int r;
    write_reg(REG_FORMAT_MODE, (ph % 3 == 0) ? 32'($urandom_range(0, 1)) : 32'(ph % 2));
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 3);
      write_reg(REG_SHORT_CODE, r == 0 ? 32'h00 : r == 1 ? 32'hFF : 32'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 3);
      write_reg(REG_LONG_CODE, r == 0 ? 32'h00 : r == 1 ? 32'hFF : 32'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 4);
      write_reg(REG_MAP_COUNT, r == 0 ? 32'd0 : r == 1 ? 32'd128 : r == 2 ? 32'd255
                             : 32'($urandom_range(1, 128)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 4);
      write_reg(REG_INIT_END, r == 0 ? 32'h0 : r == 1 ? 32'hFFFF_FFFF : r == 2 ? $urandom
                            : 32'($urandom_range(1, 60)));
    end
    if ($urandom_range(0, 9) < 6) begin
      r = $urandom_range(0, 9);
      write_reg(REG_PORT_COUNT, r == 0 ? 32'd0 : r == 1 ? 32'd3 : 32'($urandom_range(1, 2)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence: map preload, directed checks, then randomized settings phases.
  // ---------------------------------------------------------------------------
  initial begin
    int r;
    for (int i = 0; i < MAP_DEPTH; i++) map_shadow[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // every map entry gets a value, so no lookup ever hits an unloaded one
    for (int i = 0; i < MAP_DEPTH; i++) push_load(7'(i), 8'($urandom));
    wait_drained();

    // old format: escape and register 1 repairs on both sides of the init end
    write_reg(REG_FORMAT_MODE, 32'd0);
    write_reg(REG_INIT_END, 32'd4);
    write_reg(REG_PORT_COUNT, 32'd1);
    push_byte(OP_ESC);    push_byte(OP_PORT0);                       // escape in init dump
    push_byte(OP_REG1);   push_byte(8'h7F);                          // reg 1 data in init dump
    push_byte(OP_DELAY8); push_byte(8'hFF);                          // longest short delay
    push_byte(OP_REG1);   push_byte(R1_ALT_B0); push_byte(R1_TAIL_LOW);
    push_byte(8'h55);                                                // unescaped reg 1 write
    push_byte(OP_REG1);   push_byte(8'h34); push_byte(8'h12);        // 16-bit delay
    push_byte(OP_ESC);    push_byte(8'h05); push_byte(8'hAA);        // escaped low register
    push_byte(OP_PORT1);  push_byte(8'hB0); push_byte(8'h11);        // absent port, dropped
    push_byte(OP_PORT0);  push_byte(8'hFF); push_byte(8'h00);
    push_byte(OP_REG1, 1'b1);                                        // final cuts command
    push_byte(8'h10);                                                // ignored after end
    push_other(CMD_RESTART);
    push_other(CMD_UNUSED);
    wait_drained();

    // paired format: equal codes, port bit, load between pair bytes, final
    write_reg(REG_FORMAT_MODE, 32'd1);
    write_reg(REG_SHORT_CODE, 32'h10);
    write_reg(REG_LONG_CODE, 32'h10);
    write_reg(REG_MAP_COUNT, 32'd128);
    write_reg(REG_PORT_COUNT, 32'd2);
    push_byte(8'h10); push_byte(8'h05);                              // short wins on a tie
    push_byte(8'h85); push_byte(8'h77);                              // port 1, entry 5
    push_byte(8'h03); push_load(7'd3, 8'h99); push_byte(8'h44);      // load lands mid-pair
    push_byte(8'h7F); push_byte(8'hFF, 1'b1);                        // write plus end event
    push_other(CMD_RESTART);
    wait_drained();
    write_reg(REG_SHORT_CODE, 32'h00);
    write_reg(REG_LONG_CODE, 32'hFF);
    write_reg(REG_MAP_COUNT, 32'd0);
    write_reg(REG_INIT_END, 32'hFFFF_FFFF);
    push_byte(8'hFF); push_byte(8'hFF);                              // longest long delay
    push_byte(8'h00); push_byte(8'h00);
    push_byte(8'h05); push_byte(8'h12);                              // unmapped, dropped
    push_byte(8'h85, 1'b1);                                          // final on a code byte
    push_other(CMD_RESTART);
    wait_drained();

    // randomized phases, each under fresh settings with the sender drained first
    for (int ph = 0; ph < PHASES; ph++) begin
      pick_settings(ph);
      while (send_queue.size() < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 76) begin
          if (set_format) push_pair();
          else push_old_command();
        end else if (r < 84) begin
          push_byte(8'($urandom));
        end else if (r < 90) begin
          push_load(7'($urandom), 8'($urandom));
        end else if (r < 94) begin
          push_byte(8'($urandom), 1'b1);
          repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
          push_other(CMD_RESTART);
        end else if (r < 97) begin
          push_other(CMD_RESTART);
        end else begin
          push_other(CMD_UNUSED);
        end
      end
      wait_drained();
    end

    wait_drained();
    $display("Run covered %0d input transfers: map preload, directed repairs, %0d random phases",
             n_transfers, PHASES);
    $display("Checked %0d register writes and %0d end-of-stream events in both formats",
             n_writes, n_ends);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* dro_command_stream_decoder.f */
rtl/core/dcsd_pkg.sv
rtl/core/dcsd_cfg_regs.sv
rtl/core/dcsd_parser.sv
rtl/core/dcsd_out_fifo.sv
rtl/core/dro_command_stream_decoder.sv
dv/tb_dro_command_stream_decoder.sv
